### sv/ring_neighbor_exclusion_arbiter_assert.svh
// Assertion macros for the ring neighbour exclusion arbiter
`ifndef RING_NEIGHBOR_EXCLUSION_ARBITER_ASSERT_SVH
`define RING_NEIGHBOR_EXCLUSION_ARBITER_ASSERT_SVH

// same-cycle implication
`define RNEA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rnea assertion failed");

// next-cycle implication
`define RNEA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rnea assertion failed");

`endif

### sv/rnea_pkg.sv
// Types and constants shared by the ring neighbour exclusion arbiter
`timescale 1ns / 1ps
package rnea_pkg;

   localparam int MAX_SEATS_DEFAULT = 16;

   localparam int SEAT_W      = 4;
   localparam int COUNT_REG_W = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   localparam logic [COUNT_REG_W-1:0] SEAT_COUNT_RESET = 5'd5;

   // register index, taken from paddr above the byte offset
   localparam logic [CSR_ADDR_W-3:0] CSR_SEAT_COUNT = 1'b0;

   localparam logic ACTION_REQUEST = 1'b0;
   localparam logic ACTION_RELEASE = 1'b1;

   typedef enum logic [1:0] {
      SEAT_THINKING = 2'd0,
      SEAT_HUNGRY   = 2'd1,
      SEAT_EATING   = 2'd2
   } seat_state_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_MARK_HUNGRY,
      OP_MARK_THINKING,
      OP_TEST
   } cell_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARK,
      ST_TEST_SELF,
      ST_TEST_LEFT,
      ST_TEST_RIGHT,
      ST_FINISH
   } ctrl_state_type;

endpackage

### sv/rnea_if.sv
// Request and response channel interfaces
`timescale 1ns / 1ps
interface rnea_req_if;
   logic                        valid;
   logic                        ready;
   logic                        action;
   logic [rnea_pkg::SEAT_W-1:0] seat;

   modport source (output valid, action, seat, input ready);
   modport sink   (input valid, action, seat, output ready);
endinterface

interface rnea_rsp_if;
   logic valid;
   logic ready;
   logic seat_granted;
   logic left_granted;
   logic right_granted;
   logic seat_invalid;

   modport source (output valid, seat_granted, left_granted, right_granted, seat_invalid,
                   input ready);
   modport sink   (input valid, seat_granted, left_granted, right_granted, seat_invalid,
                   output ready);
endinterface

### sv/rnea_cell.sv
// One seat of the ring: holds its state and tests itself against its neighbours
`timescale 1ns / 1ps
module rnea_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  rnea_pkg::cell_op_type op,
   input  logic                  sel,
   input  logic                  left_eat,
   input  logic                  right_eat,
   output logic                  eating,
   output logic                  granted
);

   rnea_pkg::seat_state_type state_ff;
   rnea_pkg::seat_state_type state_in;

   assign eating  = (state_ff == rnea_pkg::SEAT_EATING);
   assign granted = sel && (op == rnea_pkg::OP_TEST) &&
                    (state_ff == rnea_pkg::SEAT_HUNGRY) && !left_eat && !right_eat;

   always_comb begin
      state_in = state_ff;
      case (op)
         rnea_pkg::OP_MARK_HUNGRY: begin
            if (sel) state_in = rnea_pkg::SEAT_HUNGRY;
         end
         rnea_pkg::OP_MARK_THINKING: begin
            if (sel) state_in = rnea_pkg::SEAT_THINKING;
         end
         rnea_pkg::OP_TEST: begin
            if (granted) state_in = rnea_pkg::SEAT_EATING;
         end
         default: state_in = state_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rnea_pkg::SEAT_THINKING;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/rnea_ring.sv
// Row of seat cells with wrap-around at the active seat count
`timescale 1ns / 1ps
module rnea_ring #(
   parameter int MAX_SEATS = rnea_pkg::MAX_SEATS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  rnea_pkg::cell_op_type        op,
   input  logic [$clog2(MAX_SEATS)-1:0] target,
   input  logic [$clog2(MAX_SEATS)-1:0] last_idx,
   output logic                         grant
);

   `include "ring_neighbor_exclusion_arbiter_assert.svh"

   localparam int IDX_W = $clog2(MAX_SEATS);

   logic [MAX_SEATS-1:0] eat_vec;
   logic [MAX_SEATS-1:0] grant_vec;
   logic                 wrap_eat;

   // eating flag of the last active seat, left neighbour of seat 0
   assign wrap_eat = eat_vec[last_idx];
   assign grant    = |grant_vec;

   for (genvar i = 0; i < MAX_SEATS; i++) begin : g_cell
      localparam int NEXT = (i + 1) % MAX_SEATS;
      localparam int PREV = (i == 0) ? 0 : i - 1;
      logic left_eat;
      logic right_eat;

      if (i == 0) begin : g_first
         assign left_eat = wrap_eat;
      end else begin : g_rest
         assign left_eat = eat_vec[PREV];
      end

      assign right_eat = (IDX_W'(i) == last_idx) ? eat_vec[0] : eat_vec[NEXT];

      rnea_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .op        (op),
         .sel       (target == IDX_W'(i)),
         .left_eat  (left_eat),
         .right_eat (right_eat),
         .eating    (eat_vec[i]),
         .granted   (grant_vec[i])
      );
   end

   `RNEA_ASSERT_NEXT(a_test_adds_one_eater, clock, reset, (op == rnea_pkg::OP_TEST) && grant, $countones(eat_vec) == $past($countones(eat_vec)) + 1)
   `RNEA_ASSERT_NEXT(a_mark_adds_no_eater, clock, reset, (op == rnea_pkg::OP_MARK_HUNGRY) || (op == rnea_pkg::OP_MARK_THINKING), $countones(eat_vec) <= $past($countones(eat_vec)))

endmodule

### sv/ring_neighbor_exclusion_arbiter.sv
// Top level: sequencer, register port and seat ring of the neighbour exclusion arbiter
//
//   channel  role     handshake          payload
//   req_chan input    valid/ready        action, seat
//   rsp_chan output   valid/ready        seat_granted, left_granted, right_granted, seat_invalid
//   csr_*    config   APB, pready high   seat_count at byte address 0
//
// One transaction at a time: a request marks the seat and tests it; a release marks the seat
// and then tests the left and the right neighbour; an out-of-range seat goes straight to the
// result. The sequencer drives one command into the cell row per cycle (mark, then one test per
// cycle). Synchronous reset sets every seat to thinking and seat_count to 5. A stalled result
// holds in the output register; the next request is taken once that register has been loaded.
`timescale 1ns / 1ps
module ring_neighbor_exclusion_arbiter #(
   parameter int MAX_SEATS = rnea_pkg::MAX_SEATS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   rnea_req_if.sink                            req_chan,
   rnea_rsp_if.source                          rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rnea_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [rnea_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rnea_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   `include "ring_neighbor_exclusion_arbiter_assert.svh"

   localparam int IDX_W   = $clog2(MAX_SEATS);
   localparam int COUNT_W = $clog2(MAX_SEATS + 1);
   localparam int CMP_W   = (COUNT_W > rnea_pkg::SEAT_W) ? COUNT_W : rnea_pkg::SEAT_W;

   rnea_pkg::ctrl_state_type state_ff, state_in;

   logic [rnea_pkg::COUNT_REG_W-1:0] seat_count_ff, seat_count_in;
   logic                             action_ff, action_in;
   logic [IDX_W-1:0]                 seat_idx_ff, seat_idx_in;
   logic                             invalid_ff, invalid_in;
   logic                             self_ff, self_in;
   logic                             left_ff, left_in;
   logic                             right_ff, right_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_seat_granted_ff, rsp_seat_granted_in;
   logic rsp_left_granted_ff, rsp_left_granted_in;
   logic rsp_right_granted_ff, rsp_right_granted_in;
   logic rsp_seat_invalid_ff, rsp_seat_invalid_in;

   logic [COUNT_W-1:0]                 n_eff;
   logic [IDX_W-1:0]                   last_idx;
   logic [IDX_W-1:0]                   left_idx;
   logic [IDX_W-1:0]                   right_idx;
   logic [IDX_W-1:0]                   target;
   rnea_pkg::cell_op_type              cell_op;
   logic                               grant;
   logic                               csr_write;
   logic [rnea_pkg::CSR_ADDR_W-3:0]    csr_index;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[rnea_pkg::CSR_ADDR_W-1:2];
   assign csr_prdata = (csr_index == rnea_pkg::CSR_SEAT_COUNT) ?
                       {{(rnea_pkg::CSR_DATA_W - rnea_pkg::COUNT_REG_W){1'b0}}, seat_count_ff} :
                       '0;

   always_comb begin
      seat_count_in = seat_count_ff;
      if (csr_write && (csr_index == rnea_pkg::CSR_SEAT_COUNT)) begin
         seat_count_in = csr_pwdata[rnea_pkg::COUNT_REG_W-1:0];
      end
   end

   // ring geometry
   assign n_eff     = (int'(seat_count_ff) > MAX_SEATS) ? COUNT_W'(MAX_SEATS) :
                                                          COUNT_W'(seat_count_ff);
   assign last_idx  = IDX_W'(n_eff - COUNT_W'(1));
   assign left_idx  = (seat_idx_ff == '0) ? last_idx : seat_idx_ff - IDX_W'(1);
   assign right_idx = (seat_idx_ff == last_idx) ? '0 : seat_idx_ff + IDX_W'(1);

   assign req_chan.ready         = (state_ff == rnea_pkg::ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.seat_granted  = rsp_seat_granted_ff;
   assign rsp_chan.left_granted  = rsp_left_granted_ff;
   assign rsp_chan.right_granted = rsp_right_granted_ff;
   assign rsp_chan.seat_invalid  = rsp_seat_invalid_ff;

   always_comb begin
      state_in             = state_ff;
      action_in            = action_ff;
      seat_idx_in          = seat_idx_ff;
      invalid_in           = invalid_ff;
      self_in              = self_ff;
      left_in              = left_ff;
      right_in             = right_ff;
      cell_op              = rnea_pkg::OP_HOLD;
      target               = seat_idx_ff;
      rsp_valid_in         = rsp_valid_ff && !rsp_chan.ready;
      rsp_seat_granted_in  = rsp_seat_granted_ff;
      rsp_left_granted_in  = rsp_left_granted_ff;
      rsp_right_granted_in = rsp_right_granted_ff;
      rsp_seat_invalid_in  = rsp_seat_invalid_ff;
      case (state_ff)
         rnea_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               action_in   = req_chan.action;
               seat_idx_in = IDX_W'(req_chan.seat);
               invalid_in  = CMP_W'(req_chan.seat) >= CMP_W'(n_eff);
               self_in     = 1'b0;
               left_in     = 1'b0;
               right_in    = 1'b0;
               state_in    = rnea_pkg::ST_MARK;
            end
         end
         rnea_pkg::ST_MARK: begin
            if (invalid_ff) begin
               state_in = rnea_pkg::ST_FINISH;
            end else if (action_ff == rnea_pkg::ACTION_REQUEST) begin
               cell_op  = rnea_pkg::OP_MARK_HUNGRY;
               state_in = rnea_pkg::ST_TEST_SELF;
            end else begin
               cell_op  = rnea_pkg::OP_MARK_THINKING;
               state_in = rnea_pkg::ST_TEST_LEFT;
            end
         end
         rnea_pkg::ST_TEST_SELF: begin
            cell_op  = rnea_pkg::OP_TEST;
            self_in  = grant;
            state_in = rnea_pkg::ST_FINISH;
         end
         rnea_pkg::ST_TEST_LEFT: begin
            cell_op  = rnea_pkg::OP_TEST;
            target   = left_idx;
            left_in  = grant;
            state_in = rnea_pkg::ST_TEST_RIGHT;
         end
         rnea_pkg::ST_TEST_RIGHT: begin
            cell_op  = rnea_pkg::OP_TEST;
            target   = right_idx;
            right_in = grant;
            state_in = rnea_pkg::ST_FINISH;
         end
         rnea_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in         = 1'b1;
               rsp_seat_granted_in  = self_ff;
               rsp_left_granted_in  = left_ff;
               rsp_right_granted_in = right_ff;
               rsp_seat_invalid_in  = invalid_ff;
               state_in             = rnea_pkg::ST_IDLE;
            end
         end
         default: state_in = rnea_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rnea_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         seat_count_ff <= rnea_pkg::SEAT_COUNT_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         seat_count_ff <= seat_count_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff            <= action_in;
      seat_idx_ff          <= seat_idx_in;
      invalid_ff           <= invalid_in;
      self_ff              <= self_in;
      left_ff              <= left_in;
      right_ff             <= right_in;
      rsp_seat_granted_ff  <= rsp_seat_granted_in;
      rsp_left_granted_ff  <= rsp_left_granted_in;
      rsp_right_granted_ff <= rsp_right_granted_in;
      rsp_seat_invalid_ff  <= rsp_seat_invalid_in;
   end

   rnea_ring #(
      .MAX_SEATS (MAX_SEATS)
   ) u_ring (
      .clock    (clock),
      .reset    (reset),
      .op       (cell_op),
      .target   (target),
      .last_idx (last_idx),
      .grant    (grant)
   );

   `RNEA_ASSERT_SAME(a_invalid_grants_none, clock, reset, rsp_valid_ff && rsp_seat_invalid_ff, !rsp_seat_granted_ff && !rsp_left_granted_ff && !rsp_right_granted_ff)
   `RNEA_ASSERT_SAME(a_request_or_release, clock, reset, rsp_valid_ff && rsp_seat_granted_ff, !rsp_left_granted_ff && !rsp_right_granted_ff)

endmodule

### bench/testbench.sv
// Self-checking bench for the ring neighbour exclusion arbiter: directed and random traffic
`timescale 1ns / 1ps
module testbench;

   localparam int SEATS = rnea_pkg::MAX_SEATS_DEFAULT;
   localparam logic [rnea_pkg::CSR_ADDR_W-1:0] SEAT_COUNT_ADDR =
      {rnea_pkg::CSR_SEAT_COUNT, 2'b00};

   localparam logic [rnea_pkg::COUNT_REG_W-1:0] COUNTS [9] =
      '{5'd3, 5'd16, 5'd2, 5'd0, 5'd5, 5'd31, 5'd1, 5'd7, 5'd4};
   localparam int unsigned IDLE_BY_MODE [4]  = '{0, 72, 0, 35};
   localparam int unsigned STALL_BY_MODE [4] = '{0, 0, 72, 35};

   typedef struct packed {
      logic                        action;
      logic [rnea_pkg::SEAT_W-1:0] seat;
   } meal_event_type;

   typedef struct packed {
      logic seat_granted;
      logic left_granted;
      logic right_granted;
      logic seat_invalid;
   } verdict_type;

   typedef struct packed {
      meal_event_type cause;
      verdict_type    verdict;
   } outcome_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [rnea_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [rnea_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [rnea_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   rnea_req_if req_chan ();
   rnea_rsp_if rsp_chan ();

   ring_neighbor_exclusion_arbiter dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // mirror of the seat ring and the count register
   rnea_pkg::seat_state_type ring [SEATS];
   logic [rnea_pkg::COUNT_REG_W-1:0] count_reg;

   meal_event_type pending [$];
   outcome_type    verdicts_due [$];
   meal_event_type offer;
   bit             offering = 1'b0;
   int unsigned    send_idle_pct = 0;
   int unsigned    recv_stall_pct = 0;
   int             faults = 0;

   task automatic flag_fault(input string msg);
      $display("mismatch: %s", msg);
      faults++;
   endtask

   function automatic int left_of(input int s, input int n);
      return (s == 0) ? n - 1 : s - 1;
   endfunction

   function automatic int right_of(input int s, input int n);
      return (s + 1 >= n) ? 0 : s + 1;
   endfunction

   function automatic logic grant_if_free(input int s, input int n);
      if (ring[s] == rnea_pkg::SEAT_HUNGRY && ring[left_of(s, n)] != rnea_pkg::SEAT_EATING &&
          ring[right_of(s, n)] != rnea_pkg::SEAT_EATING) begin
         ring[s] = rnea_pkg::SEAT_EATING;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic verdict_type arbitrate(input meal_event_type ev);
      int          n;
      verdict_type v;
      n = (count_reg > SEATS) ? SEATS : int'(count_reg);
      v = '0;
      if (int'(ev.seat) >= n) begin
         v.seat_invalid = 1'b1;
      end else if (ev.action == rnea_pkg::ACTION_REQUEST) begin
         ring[ev.seat] = rnea_pkg::SEAT_HUNGRY;
         void'(grant_if_free(ev.seat, n));
         v.seat_granted = (ring[ev.seat] == rnea_pkg::SEAT_EATING);
      end else begin
         ring[ev.seat] = rnea_pkg::SEAT_THINKING;
         v.left_granted  = grant_if_free(left_of(ev.seat, n), n);
         v.right_granted = grant_if_free(right_of(ev.seat, n), n);
      end
      return v;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid  <= 1'b0;
         req_chan.action <= rnea_pkg::ACTION_REQUEST;
         req_chan.seat   <= '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            verdicts_due.push_back('{cause: offer, verdict: arbitrate(offer)});
            offering = 1'b0;
         end
         if (!offering && pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            offer = pending.pop_front();
            offering = 1'b1;
            req_chan.action <= offer.action;
            req_chan.seat   <= offer.seat;
         end
         req_chan.valid <= offering;
      end
   end

   // response monitor
   always @(posedge clock) begin
      verdict_type got;
      outcome_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = {rsp_chan.seat_granted, rsp_chan.left_granted, rsp_chan.right_granted,
                   rsp_chan.seat_invalid};
            if (verdicts_due.size() == 0) begin
               flag_fault($sformatf("unexpected transaction, fields %4b", got));
            end else begin
               want = verdicts_due.pop_front();
               if (got !== want.verdict)
                  flag_fault($sformatf("%s seat %0d: got %4b expected %4b (own/left/right/inv)",
                     (want.cause.action == rnea_pkg::ACTION_RELEASE) ? "release" : "request",
                     want.cause.seat, got, want.verdict));
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic queue_event(input logic act, input logic [rnea_pkg::SEAT_W-1:0] s);
      pending.push_back('{action: act, seat: s});
   endtask

   task automatic await_quiet();
      do @(posedge clock);
      while (pending.size() != 0 || offering || verdicts_due.size() != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_seat_count(input logic [rnea_pkg::COUNT_REG_W-1:0] value);
      logic [rnea_pkg::CSR_DATA_W-1:0] readback;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= SEAT_COUNT_ADDR;
      csr_pwdata  <= rnea_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      count_reg = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== rnea_pkg::CSR_DATA_W'(value))
         flag_fault($sformatf("seat_count read %0h after writing %0h", readback, value));
   endtask

   task automatic run_random(input int items, input int unsigned idle, input int unsigned stall);
      int n;
      logic [rnea_pkg::SEAT_W-1:0] s;
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      n = (count_reg > SEATS) ? SEATS : int'(count_reg);
      for (int k = 0; k < items; k++) begin
         if (n != 0 && $urandom_range(99) < 85) s = rnea_pkg::SEAT_W'($urandom_range(n - 1));
         else s = rnea_pkg::SEAT_W'($urandom_range(SEATS - 1));
         queue_event(($urandom_range(99) < 55) ? rnea_pkg::ACTION_REQUEST :
                                                 rnea_pkg::ACTION_RELEASE, s);
         // sender holds off until the block has drained
         if (k == items / 2) await_quiet();
      end
      await_quiet();
   endtask

   initial begin
      for (int k = 0; k < SEATS; k++) ring[k] = rnea_pkg::SEAT_THINKING;
      count_reg = rnea_pkg::SEAT_COUNT_RESET;
      reset       <= 1'b1;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // five seats after reset: waits, neighbour grants, re-request, invalid seats
      queue_event(rnea_pkg::ACTION_REQUEST, 4'd0);
      queue_event(rnea_pkg::ACTION_REQUEST, 4'd1);
      queue_event(rnea_pkg::ACTION_REQUEST, 4'd4);
      queue_event(rnea_pkg::ACTION_REQUEST, 4'd2);
      queue_event(rnea_pkg::ACTION_RELEASE, 4'd0);
      queue_event(rnea_pkg::ACTION_REQUEST, 4'd4);
      queue_event(rnea_pkg::ACTION_RELEASE, 4'd3);
      queue_event(rnea_pkg::ACTION_REQUEST, 4'd5);
      queue_event(rnea_pkg::ACTION_RELEASE, 4'd15);
      await_quiet();
      // single seat is its own neighbour
      set_seat_count(5'd1);
      queue_event(rnea_pkg::ACTION_REQUEST, 4'd0);
      queue_event(rnea_pkg::ACTION_REQUEST, 4'd0);
      queue_event(rnea_pkg::ACTION_RELEASE, 4'd0);
      await_quiet();
      // two seats: only the left test can grant
      set_seat_count(5'd2);
      queue_event(rnea_pkg::ACTION_REQUEST, 4'd0);
      queue_event(rnea_pkg::ACTION_REQUEST, 4'd1);
      queue_event(rnea_pkg::ACTION_RELEASE, 4'd0);
      await_quiet();
      set_seat_count(5'd0);
      queue_event(rnea_pkg::ACTION_REQUEST, 4'd0);
      queue_event(rnea_pkg::ACTION_RELEASE, 4'd0);
      await_quiet();
      // oversized count saturates to the full ring
      set_seat_count(5'd31);
      queue_event(rnea_pkg::ACTION_REQUEST, 4'd15);
      queue_event(rnea_pkg::ACTION_REQUEST, 4'd0);
      queue_event(rnea_pkg::ACTION_RELEASE, 4'd15);
      queue_event(rnea_pkg::ACTION_REQUEST, 4'd10);
      queue_event(rnea_pkg::ACTION_RELEASE, 4'd5);
      await_quiet();
      set_seat_count(5'd16);
      queue_event(rnea_pkg::ACTION_REQUEST, 4'd1);
      queue_event(rnea_pkg::ACTION_RELEASE, 4'd1);
      await_quiet();

      for (int p = 0; p < 9; p++) begin
         set_seat_count(COUNTS[p]);
         run_random((COUNTS[p] == 0) ? 12 : 48, IDLE_BY_MODE[p % 4], STALL_BY_MODE[p % 4]);
      end

      repeat (10) @(posedge clock);
      if (faults == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
